@@ hw/rtl/source_text_tokenizer_assert.svh @@
// assertion helpers, used inside modules that have clk and arst_n
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH

// same-cycle implication
`define STT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/stt_pkg.sv @@
package stt_pkg;

	localparam int OFFSET_BITS = 24;
	localparam int OUT_W = 24;
	localparam int LINE_W = 24;
	localparam int VAL_W = 63;
	localparam int RES_MAX = 3;
	localparam int RES_CNT_W = $clog2(RES_MAX + 1);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [3:0] KIND_COMMA = 4'd0;
	localparam logic [3:0] KIND_SEMI = 4'd1;
	localparam logic [3:0] KIND_COLON = 4'd2;
	localparam logic [3:0] KIND_MINUS = 4'd3;
	localparam logic [3:0] KIND_BRACKET = 4'd4;
	localparam logic [3:0] KIND_BINOP = 4'd5;
	localparam logic [3:0] KIND_ASSIGN = 4'd6;
	localparam logic [3:0] KIND_STRING = 4'd7;
	localparam logic [3:0] KIND_INT = 4'd8;
	localparam logic [3:0] KIND_FLOAT = 4'd9;
	localparam logic [3:0] KIND_UNKNOWN = 4'd10;
	localparam logic [3:0] KIND_UNTERM = 4'd11;
	localparam logic [3:0] KIND_END = 4'd12;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       is_final;
	} in_t;

	typedef struct packed {
		logic [3:0]        token_kind;
		logic [7:0]        first_char;
		logic [7:0]        second_char;
		logic [OUT_W-1:0]  start_offset;
		logic [OUT_W-1:0]  text_length;
		logic [VAL_W-1:0]  int_value;
		logic [LINE_W-1:0] line_number;
		logic              is_last;
	} tok_t;

	typedef struct packed {
		logic [RES_CNT_W-1:0]   n;
		tok_t [RES_MAX-1:0]     tok;
	} res_bundle_t;

	// low output bits of an offset, zero-extended when offsets are narrow
	function automatic logic [OUT_W-1:0] to_out(input logic [OFFSET_BITS-1:0] x);
		logic [OFFSET_BITS+OUT_W-1:0] w;
		w = {{OUT_W{1'b0}}, x};
		return w[OUT_W-1:0];
	endfunction

	function automatic tok_t make_tok(
		input logic [3:0]             kind,
		input logic [7:0]             c1,
		input logic [7:0]             c2,
		input logic [OFFSET_BITS-1:0] start,
		input logic [OFFSET_BITS-1:0] len,
		input logic [VAL_W-1:0]       val,
		input logic [LINE_W-1:0]      line
	);
		tok_t t;
		t.token_kind = kind;
		t.first_char = c1;
		t.second_char = c2;
		t.start_offset = to_out(start);
		t.text_length = to_out(len);
		t.int_value = val;
		t.line_number = line;
		t.is_last = 1'b0;
		return t;
	endfunction

endpackage

@@ hw/rtl/source_text_tokenizer.sv @@
// source text tokenizer
// byte channel: byte_valid / byte_stall / byte_data, one source byte per
// transfer, byte_data.is_final marks the last byte of a text. the final byte
// flushes any pending token, adds an end token and returns the lexer to its
// reset state, so the next byte starts a new text at offset 0, line 1.
// token channel: token_valid / token_stall / token_data, one token per
// transfer; token_data.is_last marks the last token caused by a byte.
// a taken byte sits in one input register; the lexer pushes its tokens, up
// to three, into a four-entry token queue, from which they leave. throughput:
// one byte per cycle while bytes give at most one token each and the token
// receiver does not stall; a byte that gives several tokens takes one token
// transfer per token. byte_stall rises when the queue cannot take a full
// bundle, i.e. when the token receiver stalls or falls behind. no token is
// lost or repeated under any stall pattern. reset empties the queue and the
// input register and sets the lexer to idle, offset 0, line 1; no clearing
// pass is needed.
module source_text_tokenizer import stt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic byte_valid,
	output logic byte_stall,
	input  in_t  byte_data,
	output logic token_valid,
	input  logic token_stall,
	output tok_t token_data
);

	in_t         data_s1;
	logic        valid_s1;
	logic        room;
	logic        go;
	logic        accept;
	res_bundle_t res;

	assign go = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;
	assign accept = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= byte_data;
		end
	end

	stt_lexer u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.item   (data_s1),
		.res    (res)
	);

	stt_res_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.res         (res),
		.room        (room),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_data  (token_data)
	);

endmodule

@@ hw/rtl/stt_lexer.sv @@
module stt_lexer import stt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  in_t         item,
	output res_bundle_t res
);

	localparam logic [2:0] MODE_IDLE = 3'd0;
	localparam logic [2:0] MODE_COMMENT = 3'd1;
	localparam logic [2:0] MODE_STRING = 3'd2;
	localparam logic [2:0] MODE_NUMBER = 3'd3;
	localparam logic [2:0] MODE_HOLD = 3'd4;

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_DQ = 8'h22;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_AMP = 8'h26;
	localparam logic [7:0] CH_SQ = 8'h27;
	localparam logic [7:0] CH_LP = 8'h28;
	localparam logic [7:0] CH_RP = 8'h29;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_LT = 8'h3C;
	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_GT = 8'h3E;
	localparam logic [7:0] CH_LB = 8'h5B;
	localparam logic [7:0] CH_BSL = 8'h5C;
	localparam logic [7:0] CH_RB = 8'h5D;
	localparam logic [7:0] CH_X = 8'h78;
	localparam logic [7:0] CH_LC = 8'h7B;
	localparam logic [7:0] CH_BAR = 8'h7C;
	localparam logic [7:0] CH_RC = 8'h7D;

	localparam logic [LINE_W-1:0] LINE_ONE = LINE_W'(1);
	localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
	localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
	localparam logic [OFFSET_BITS-1:0] LEN_ONE = OFFSET_BITS'(1);
	localparam logic [OFFSET_BITS-1:0] LEN_TWO = OFFSET_BITS'(2);
	localparam int NCAND = 4;

	logic [2:0]             mode_q, mode_d;
	logic [7:0]             held_q, held_d;
	logic [7:0]             quote_q, quote_d;
	logic [7:0]             prev_q, prev_d;
	logic [LINE_W-1:0]      line_q, line_d;
	logic [OFFSET_BITS-1:0] offset_q, offset_d;
	logic [OFFSET_BITS-1:0] tstart_q, tstart_d;
	logic [LINE_W-1:0]      tline_q, tline_d;
	logic                   point_q, point_d;
	logic                   hex_q, hex_d;
	logic [VAL_W-1:0]       acc_q, acc_d;
	logic                   frozen_q, frozen_d;

	logic [7:0]       b;
	logic             fin;
	logic             is_digit;
	logic [7:0]       dsub;
	logic [VAL_W+3:0] acc_next;
	logic             pair;

	assign b = item.text_byte;
	assign fin = item.is_final;
	assign is_digit = (b >= CH_0) && (b <= CH_9);
	assign dsub = b - CH_0;
	// acc * 10 + digit, kept wide so saturation is a plain compare
	assign acc_next = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {{VAL_W{1'b0}}, dsub[3:0]};
	assign pair = ((b == CH_EQ) && (held_q == CH_LT || held_q == CH_GT || held_q == CH_EQ)) ||
		((b == held_q) && (held_q == CH_AMP || held_q == CH_BAR));

	always_comb begin
		tok_t [NCAND-1:0]  cand;
		logic [NCAND-1:0]  cand_v;
		logic              again;
		logic [2:0]        k;
		cand = '0;
		cand_v = '0;
		again = 1'b0;
		k = 3'd0;
		mode_d = mode_q;
		held_d = held_q;
		quote_d = quote_q;
		line_d = line_q;
		tstart_d = tstart_q;
		tline_d = tline_q;
		point_d = point_q;
		hex_d = hex_q;
		acc_d = acc_q;
		frozen_d = frozen_q;

		// byte against the pending token
		case (mode_q)
			MODE_HOLD: begin
				cand_v[0] = 1'b1;
				mode_d = MODE_IDLE;
				if (pair) begin
					cand[0] = make_tok(KIND_BINOP, held_q, b, tstart_q, LEN_TWO, '0, tline_q);
				end else begin
					cand[0] = make_tok((held_q == CH_EQ) ? KIND_ASSIGN : KIND_BINOP, held_q,
						8'h00, tstart_q, LEN_ONE, '0, tline_q);
					again = 1'b1;
				end
			end
			MODE_COMMENT: begin
				if (b == CH_NL) begin
					mode_d = MODE_IDLE;
					again = 1'b1;
				end
			end
			MODE_STRING: begin
				if (b == quote_q && prev_q != CH_BSL) begin
					cand_v[0] = 1'b1;
					cand[0] = make_tok(KIND_STRING, 8'h00, 8'h00, tstart_q,
						offset_q - tstart_q, '0, tline_q);
					mode_d = MODE_IDLE;
				end
			end
			MODE_NUMBER: begin
				if (is_digit) begin
					if (!frozen_q) begin
						acc_d = (acc_next > {4'b0, VAL_MAX}) ? VAL_MAX : acc_next[VAL_W-1:0];
					end
				end else if (b == CH_DOT && !point_q) begin
					point_d = 1'b1;
					frozen_d = 1'b1;
				end else if (b == CH_X && !hex_q) begin
					hex_d = 1'b1;
					frozen_d = 1'b1;
				end else begin
					cand_v[0] = 1'b1;
					cand[0] = make_tok(point_q ? KIND_FLOAT : KIND_INT, 8'h00, 8'h00, tstart_q,
						offset_q - tstart_q, acc_q, tline_q);
					mode_d = MODE_IDLE;
					again = 1'b1;
				end
			end
			default: begin
				mode_d = MODE_IDLE;
				again = 1'b1;
			end
		endcase

		// byte on its own, from idle
		if (again) begin
			case (b)
				CH_HASH: mode_d = MODE_COMMENT;
				CH_NL: begin
					if (line_q != LINE_MAX) begin
						line_d = line_q + LINE_ONE;
					end
				end
				CH_SP, CH_TAB, CH_VT, CH_FF, CH_CR: begin
				end
				CH_SQ, CH_DQ: begin
					mode_d = MODE_STRING;
					quote_d = b;
					tstart_d = offset_q + LEN_ONE;
					tline_d = line_q;
				end
				CH_COMMA, CH_SEMI, CH_COLON, CH_MINUS: begin
					cand_v[1] = 1'b1;
					cand[1] = make_tok((b == CH_COMMA) ? KIND_COMMA :
						(b == CH_SEMI) ? KIND_SEMI :
						(b == CH_COLON) ? KIND_COLON : KIND_MINUS,
						b, 8'h00, offset_q, LEN_ONE, '0, line_q);
				end
				CH_LB, CH_RB, CH_LC, CH_RC, CH_LP, CH_RP: begin
					cand_v[1] = 1'b1;
					cand[1] = make_tok(KIND_BRACKET, b, 8'h00, offset_q, LEN_ONE, '0, line_q);
				end
				CH_PLUS, CH_STAR, CH_SLASH: begin
					cand_v[1] = 1'b1;
					cand[1] = make_tok(KIND_BINOP, b, 8'h00, offset_q, LEN_ONE, '0, line_q);
				end
				CH_LT, CH_GT, CH_EQ, CH_AMP, CH_BAR: begin
					mode_d = MODE_HOLD;
					held_d = b;
					tstart_d = offset_q;
					tline_d = line_q;
				end
				default: begin
					if (is_digit) begin
						mode_d = MODE_NUMBER;
						tstart_d = offset_q;
						tline_d = line_q;
						point_d = 1'b0;
						hex_d = 1'b0;
						frozen_d = 1'b0;
						acc_d = {{(VAL_W-4){1'b0}}, dsub[3:0]};
					end else begin
						cand_v[1] = 1'b1;
						cand[1] = make_tok(KIND_UNKNOWN, b, 8'h00, offset_q, LEN_ONE, '0, line_q);
					end
				end
			endcase
		end

		prev_d = b;
		offset_d = offset_q + LEN_ONE;

		// end of text: flush, end mark, back to reset values
		if (fin) begin
			case (mode_d)
				MODE_HOLD: begin
					cand_v[2] = 1'b1;
					cand[2] = make_tok((held_d == CH_EQ) ? KIND_ASSIGN : KIND_BINOP, held_d,
						8'h00, tstart_d, LEN_ONE, '0, tline_d);
				end
				MODE_NUMBER: begin
					cand_v[2] = 1'b1;
					cand[2] = make_tok(point_d ? KIND_FLOAT : KIND_INT, 8'h00, 8'h00, tstart_d,
						offset_d - tstart_d, acc_d, tline_d);
				end
				MODE_STRING: begin
					cand_v[2] = 1'b1;
					cand[2] = make_tok(KIND_UNTERM, 8'h00, 8'h00, tstart_d,
						offset_d - tstart_d, '0, tline_d);
				end
				default: begin
				end
			endcase
			cand_v[3] = 1'b1;
			cand[3] = make_tok(KIND_END, 8'h00, 8'h00, offset_d, '0, '0, line_d);
			mode_d = MODE_IDLE;
			held_d = '0;
			quote_d = '0;
			prev_d = '0;
			line_d = LINE_ONE;
			offset_d = '0;
			tstart_d = '0;
			tline_d = LINE_ONE;
			point_d = 1'b0;
			hex_d = 1'b0;
			acc_d = '0;
			frozen_d = 1'b0;
		end

		// pack candidates in order; anything past the third is dropped
		res.tok = '0;
		for (int i = 0; i < NCAND; i++) begin
			if (cand_v[i] && k < 3'(RES_MAX)) begin
				res.tok[k[RES_CNT_W-1:0]] = cand[i];
				k = k + 3'd1;
			end
		end
		for (int j = 0; j < RES_MAX; j++) begin
			res.tok[j].is_last = (3'(j) + 3'd1 == k);
		end
		res.n = go ? k[RES_CNT_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			held_q <= '0;
			quote_q <= '0;
			prev_q <= '0;
			line_q <= LINE_ONE;
			offset_q <= '0;
			tstart_q <= '0;
			tline_q <= LINE_ONE;
			point_q <= 1'b0;
			hex_q <= 1'b0;
			acc_q <= '0;
			frozen_q <= 1'b0;
		end else if (go) begin
			mode_q <= mode_d;
			held_q <= held_d;
			quote_q <= quote_d;
			prev_q <= prev_d;
			line_q <= line_d;
			offset_q <= offset_d;
			tstart_q <= tstart_d;
			tline_q <= tline_d;
			point_q <= point_d;
			hex_q <= hex_d;
			acc_q <= acc_d;
			frozen_q <= frozen_d;
		end
	end

	`include "source_text_tokenizer_assert.svh"

	`STT_NEXT(a_final_resets, go && fin,
		offset_q == '0 && line_q == LINE_ONE && mode_q == MODE_IDLE,
		"state not cleared after final byte")
	`STT_IMPLIES(a_hold_char, mode_q == MODE_HOLD,
		held_q == CH_LT || held_q == CH_GT || held_q == CH_EQ || held_q == CH_AMP ||
		held_q == CH_BAR, "held operator byte out of set")
	`STT_IMPLIES(a_quote_char, mode_q == MODE_STRING,
		quote_q == CH_SQ || quote_q == CH_DQ, "string without a quote byte")
	`STT_IMPLIES(a_final_emits, go && fin, res.n != '0, "final byte produced no token")

endmodule

@@ hw/rtl/stt_res_queue.sv @@
module stt_res_queue import stt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  res_bundle_t res,
	output logic        room,
	output logic        token_valid,
	input  logic        token_stall,
	output tok_t        token_data
);

	tok_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              pop;

	assign token_valid = (count_q != '0);
	assign token_data = mem_q[rd_ptr_q];
	assign pop = token_valid && !token_stall;
	// worst case of one byte is a full bundle
	assign room = (count_q <= QCNT_W'(QUEUE_DEPTH - RES_MAX));

	always_ff @(posedge clk) begin
		for (int i = 0; i < RES_MAX; i++) begin
			if (RES_CNT_W'(i) < res.n) begin
				mem_q[wr_ptr_q + QPTR_W'(i)] <= res.tok[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(res.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(res.n) - QCNT_W'(pop);
		end
	end

	`include "source_text_tokenizer_assert.svh"

	`STT_IMPLIES(a_no_overfill, res.n != '0,
		(QCNT_W+1)'(count_q) + (QCNT_W+1)'(res.n) <= (QCNT_W+1)'(QUEUE_DEPTH),
		"token queue overfilled")
	`STT_IMPLIES(a_count_range, 1'b1, count_q <= QCNT_W'(QUEUE_DEPTH),
		"token queue count out of range")
	`STT_NEXT(a_idle_hold, res.n == '0 && !pop, count_q == $past(count_q),
		"token queue count moved without a transfer")

endmodule
